// ----- rtl/dmcc_pkg.sv -----
// Shared types and constants for the dictionary mismatch code compressor.
package dmcc_pkg;

  // Number of dictionary registers on the configuration port.
  localparam int REG_COUNT = 8;
  localparam int CFG_ADDR_BITS = 4;
  localparam int CFG_DATA_BITS = 32;

  // Field widths of the input and result words.
  localparam int INSTR_BITS = 32;
  localparam int FMT_BITS = 2;
  localparam int IDX_BITS = 3;
  localparam int POS_BITS = 5;
  localparam int CODE_BITS = 34;
  localparam int LEN_BITS = 6;
  localparam int OUT_DATA_BITS = 56;

  // Code formats, which are also the leading two bits of each code.
  localparam logic [FMT_BITS-1:0] FMT_EXACT = 2'd0;
  localparam logic [FMT_BITS-1:0] FMT_ONE_BIT = 2'd1;
  localparam logic [FMT_BITS-1:0] FMT_TWO_BIT = 2'd2;
  localparam logic [FMT_BITS-1:0] FMT_RAW = 2'd3;

  // Code lengths of the dictionary formats.
  localparam logic [LEN_BITS-1:0] LEN_EXACT = 6'd5;
  localparam logic [LEN_BITS-1:0] LEN_ONE_BIT = 6'd10;
  localparam logic [LEN_BITS-1:0] LEN_TWO_BIT = 6'd15;

  // One result word before packing.
  typedef struct packed {
    logic [LEN_BITS-1:0]  code_length;
    logic [CODE_BITS-1:0] code_bits;
    logic [POS_BITS-1:0]  second_position;
    logic [POS_BITS-1:0]  first_position;
    logic [IDX_BITS-1:0]  entry_index;
    logic [FMT_BITS-1:0]  code_format;
  } code_result_t;

endpackage

// ----- rtl/dictionary_mismatch_code_compressor.sv -----
// Top level of the dictionary mismatch code compressor.
//
//   Channel  Direction  Handshake                Payload
//   in_      slave      in_tvalid / in_tready    in_tdata: instr_word
//   out_     master     out_tvalid / out_tready  out_tdata: code result fields
//   cfg_     slave      cfg_valid / cfg_ready    cfg_addr, cfg_data
//
// Each word passes an input register and a result register: its result is on
// the output once the result register has taken it, and one word is taken
// every cycle while the output does not stall.
// The single compare, select and encode stage lies between the two registers.
// Reset clears both valid flags and the dictionary.
// A stall on the output holds the result register, and the input register
// holds only while the result register is full and not being taken.
module dictionary_mismatch_code_compressor #(
  parameter int DICT_ENTRIES = 8,
  parameter int WORD_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: instr_word [31:0]
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [dmcc_pkg::INSTR_BITS-1:0]     in_tdata,
  // out_tdata: code_format [1:0], entry_index [4:2], first_position [9:5],
  // second_position [14:10], code_bits [48:15], code_length [54:49], zero [55]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [dmcc_pkg::OUT_DATA_BITS-1:0]  out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dmcc_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
  input  logic [dmcc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam logic [dmcc_pkg::LEN_BITS-1:0] RAW_LEN = dmcc_pkg::LEN_BITS'(WORD_BITS + 2);

  logic [WORD_BITS-1:0] dict_r [dmcc_pkg::REG_COUNT];

  logic                  in_vld_r;
  logic [WORD_BITS-1:0]  word_r;
  logic                  out_vld_r;
  dmcc_pkg::code_result_t res_r;
  dmcc_pkg::code_result_t res_nxt;

  logic stage_adv;
  logic out_free;

  // Dictionary registers; writes beyond the list are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < dmcc_pkg::REG_COUNT; i++) begin
        dict_r[i] <= '0;
      end
    end else if (cfg_valid && (cfg_addr < dmcc_pkg::CFG_ADDR_BITS'(dmcc_pkg::REG_COUNT))) begin
      dict_r[cfg_addr[2:0]] <= cfg_data[WORD_BITS-1:0];
    end
  end

  // Pipeline flow control.
  assign out_free  = !out_vld_r || out_tready;
  assign stage_adv = in_vld_r && out_free;
  assign in_tready = !in_vld_r || out_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      word_r <= in_tdata[WORD_BITS-1:0];
    end
  end

  // Position, counted from the most significant bit, of a one-hot word.
  function automatic logic [dmcc_pkg::POS_BITS-1:0] onehot_pos(input logic [WORD_BITS-1:0] v);
    logic [dmcc_pkg::POS_BITS-1:0] p;
    p = '0;
    for (int k = 0; k < WORD_BITS; k++) begin
      if (v[k]) begin
        p = p | dmcc_pkg::POS_BITS'(WORD_BITS - 1 - k);
      end
    end
    return p;
  endfunction

  // Compare against every entry, pick the best kind and lowest entry, encode.
  logic [WORD_BITS-1:0] diff     [DICT_ENTRIES];
  logic [WORD_BITS-1:0] diff_low [DICT_ENTRIES];
  logic [DICT_ENTRIES-1:0] hit0, hit1, hit2;

  always_comb begin
    logic [WORD_BITS-1:0] d_sel;
    logic [WORD_BITS-1:0] dl_sel;
    logic [dmcc_pkg::IDX_BITS-1:0] idx0, idx1, idx2;
    logic found0, found1, found2;

    // Per-entry mismatch classes: none, exactly one bit, exactly two bits.
    for (int e = 0; e < DICT_ENTRIES; e++) begin
      diff[e]     = word_r ^ dict_r[e];
      diff_low[e] = diff[e] & (diff[e] - WORD_BITS'(1));
      hit0[e] = (diff[e] == '0);
      hit1[e] = (diff[e] != '0) && (diff_low[e] == '0);
      hit2[e] = (diff_low[e] != '0) && ((diff_low[e] & (diff_low[e] - WORD_BITS'(1))) == '0);
    end

    // Lowest entry within each kind.
    idx0 = '0; idx1 = '0; idx2 = '0;
    found0 = 1'b0; found1 = 1'b0; found2 = 1'b0;
    for (int e = DICT_ENTRIES - 1; e >= 0; e--) begin
      if (hit0[e]) begin
        idx0 = dmcc_pkg::IDX_BITS'(e);
        found0 = 1'b1;
      end
      if (hit1[e]) begin
        idx1 = dmcc_pkg::IDX_BITS'(e);
        found1 = 1'b1;
      end
      if (hit2[e]) begin
        idx2 = dmcc_pkg::IDX_BITS'(e);
        found2 = 1'b1;
      end
    end

    res_nxt = '0;
    d_sel   = '0;
    dl_sel  = '0;
    if (found0) begin
      res_nxt.code_format = dmcc_pkg::FMT_EXACT;
      res_nxt.entry_index = idx0;
      res_nxt.code_bits   = dmcc_pkg::CODE_BITS'(idx0);
      res_nxt.code_length = dmcc_pkg::LEN_EXACT;
    end else if (found1) begin
      // The single differing bit is the whole difference.
      d_sel = diff[idx1];
      res_nxt.code_format    = dmcc_pkg::FMT_ONE_BIT;
      res_nxt.entry_index    = idx1;
      res_nxt.first_position = onehot_pos(d_sel);
      res_nxt.code_bits      = {26'(dmcc_pkg::FMT_ONE_BIT), res_nxt.first_position, idx1};
      res_nxt.code_length    = dmcc_pkg::LEN_ONE_BIT;
    end else if (found2) begin
      // With the lowest bit dropped the upper bit is left; their xor is the lower.
      d_sel  = diff[idx2];
      dl_sel = diff_low[idx2];
      res_nxt.code_format     = dmcc_pkg::FMT_TWO_BIT;
      res_nxt.entry_index     = idx2;
      res_nxt.first_position  = onehot_pos(dl_sel);
      res_nxt.second_position = onehot_pos(d_sel ^ dl_sel);
      res_nxt.code_bits       = {21'(dmcc_pkg::FMT_TWO_BIT), res_nxt.first_position,
                                 res_nxt.second_position, idx2};
      res_nxt.code_length     = dmcc_pkg::LEN_TWO_BIT;
    end else begin
      res_nxt.code_format = dmcc_pkg::FMT_RAW;
      res_nxt.code_bits   = dmcc_pkg::CODE_BITS'(word_r)
                          | (dmcc_pkg::CODE_BITS'(dmcc_pkg::FMT_RAW) << WORD_BITS);
      res_nxt.code_length = RAW_LEN;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = dmcc_pkg::OUT_DATA_BITS'(res_r);

endmodule
